### rtl/signed_integer_to_decimal_text_assert.svh
// Assertion macros shared by the decimal text converter RTL.
// Each macro expands to one labeled concurrent assertion on a clock and a reset.
`ifndef SIGNED_INTEGER_TO_DECIMAL_TEXT_ASSERT_SVH
`define SIGNED_INTEGER_TO_DECIMAL_TEXT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high
`define SIDT_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sidt: same-cycle check failed");

// Next-cycle implication, disabled while reset is high
`define SIDT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sidt: next-cycle check failed");

`endif

### rtl/sidt_pkg.sv
// Package for the signed integer to decimal text converter.
// Holds character codes, store sizes, the state type and the core control struct.
`default_nettype none

package sidt_pkg;

   // Default input width taken by the converter
   localparam int DEFAULT_VALUE_WIDTH = 64;

   // Decimal digit store: enough digits for a 64-bit magnitude
   localparam int STORE_DEPTH = 20;
   localparam int COUNT_WIDTH = $clog2(STORE_DEPTH + 1);

   // Buffer size register
   localparam int          SIZE_WIDTH        = 6;
   localparam logic [5:0]  BUFFER_SIZE_RESET = 6'd32;

   // Text characters
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   // Shift-and-add-3 correction for a radix of ten
   localparam logic [3:0] DABBLE_THRESHOLD = 4'd5;
   localparam logic [3:0] DABBLE_ADJUST    = 4'd3;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SIGN,
      ST_DIGIT,
      ST_TERM
   } state_type;

   // Controls from the sequencer to the digit core
   typedef struct packed {
      logic clear;   // start a new conversion
      logic shift;   // take one magnitude bit, MSB first
      logic bit_in;  // the magnitude bit
      logic pop;     // drop the most significant held digit
   } dab_ctrl_type;

endpackage

`default_nettype wire

### rtl/sidt_dabble.sv
// Bit-serial binary to BCD core (shift and add 3) with the decimal digit store.
// Depends on sidt_pkg for the store depth, correction constants and control struct.
`default_nettype none

module sidt_dabble
   import sidt_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire dab_ctrl_type           ctrl,
   output logic [COUNT_WIDTH-1:0]      digit_count,
   output logic [3:0]                  top_digit
);

   logic [3:0]             store_ff [STORE_DEPTH];
   logic [3:0]             store_in [STORE_DEPTH];
   logic [STORE_DEPTH-1:0] occ_ff;
   logic [STORE_DEPTH-1:0] occ_in;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;
   logic [COUNT_WIDTH-1:0] rd_idx;
   logic [3:0]             adj [STORE_DEPTH];
   logic                   grow;

   // Correct each digit, then shift the chain left by one bit
   always_comb begin
      logic [3:0] eff;
      for (int i = 0; i < STORE_DEPTH; i++) begin
         // digits above the highest nonzero one are zero, written or not
         eff = occ_ff[i] ? store_ff[i] : 4'd0;
         adj[i] = (eff >= DABBLE_THRESHOLD) ? (eff + DABBLE_ADJUST) : eff;
      end
      store_in[0] = {adj[0][2:0], ctrl.bit_in};
      for (int i = 1; i < STORE_DEPTH; i++) begin
         store_in[i] = {adj[i][2:0], adj[i-1][3]};
      end
      for (int i = 0; i < STORE_DEPTH; i++) begin
         occ_in[i] = occ_ff[i] | (store_in[i] != 4'd0);
      end
      // the magnitude gains at most one digit per shift
      grow = |(occ_in & ~occ_ff);
   end

   // Track the number of significant digits
   always_comb begin
      count_in = count_ff;
      if (ctrl.clear) begin
         count_in = '0;
      end else if (ctrl.shift) begin
         count_in = count_ff + COUNT_WIDTH'(grow);
      end else if (ctrl.pop && count_ff != '0) begin
         count_in = count_ff - COUNT_WIDTH'(1);
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         occ_ff   <= '0;
      end else begin
         count_ff <= count_in;
         if (ctrl.clear) begin
            occ_ff <= '0;
         end else if (ctrl.shift) begin
            occ_ff <= occ_in;
         end
      end
   end

   // Advance the digit chain
   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         for (int i = 0; i < STORE_DEPTH; i++) begin
            store_ff[i] <= store_in[i];
         end
      end
   end

   // Read the most significant held digit
   assign rd_idx      = count_ff - COUNT_WIDTH'(1);
   assign top_digit   = (count_ff != '0) ? store_ff[rd_idx] : 4'd0;
   assign digit_count = count_ff;

endmodule

`default_nettype wire

### rtl/signed_integer_to_decimal_text.sv
// Top level of the signed integer to decimal text converter: sequencer, sign and output.
// Depends on sidt_pkg, sidt_dabble and signed_integer_to_decimal_text_assert.svh.
//
//   channel   ports                                   transaction
//   input     start, busy, req_value                  start high while busy low
//   result    rsp_valid, rsp_character, rsp_last      rsp_valid high for one cycle
//   config    csr_write_enable, csr_write_data        csr_write_enable high
//
// An item runs through the convert state (a bit-serial shift-and-add-3 pass over the magnitude),
// then sign, digit (skipped for zero) and term; the digit state's last pass emits no character.
// Characters leave one per cycle while digits are shown; sign shows none for a positive value.
// Busy drops as the NUL is shown. A buffer size of zero makes start do nothing.
// Reset is synchronous, active high, and sets the buffer size to 32.
// Results cannot be stalled by the receiver.
`default_nettype none
`include "signed_integer_to_decimal_text_assert.svh"

module signed_integer_to_decimal_text
   import sidt_pkg::*;
#(
   parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic signed [63:0]     req_value,
   output logic                        rsp_valid,
   output logic [7:0]                  rsp_character,
   output logic                        rsp_last,
   input  wire logic                   csr_write_enable,
   input  wire logic [SIZE_WIDTH-1:0]  csr_write_data
);

   localparam int BIT_CNT_W = $clog2(VALUE_WIDTH + 1);

   state_type              state_ff, state_in;
   logic [SIZE_WIDTH-1:0]  size_ff;
   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic                   neg_ff, neg_in;
   logic [BIT_CNT_W-1:0]   bits_ff, bits_in;
   logic [4:0]             pos_ff, pos_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_character_ff, rsp_character_in;
   logic                   rsp_last_ff, rsp_last_in;

   dab_ctrl_type           dab_ctrl;
   logic [COUNT_WIDTH-1:0] digit_count;
   logic [3:0]             top_digit;

   logic                   accept;
   logic                   room;
   logic [VALUE_WIDTH-1:0] value_bits;
   logic                   emit;
   logic                   is_text_char;

   sidt_dabble u_dabble (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (dab_ctrl),
      .digit_count (digit_count),
      .top_digit   (top_digit)
   );

   assign accept     = start && !busy && (size_ff != '0);
   assign room       = ({1'b0, pos_ff} + 6'd1) < size_ff;
   assign value_bits = req_value[VALUE_WIDTH-1:0];

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_CONVERT;
         end
         ST_CONVERT: begin
            if (bits_ff == BIT_CNT_W'(1)) state_in = ST_SIGN;
         end
         ST_SIGN: begin
            state_in = (digit_count == '0) ? ST_TERM : ST_DIGIT;
         end
         ST_DIGIT: begin
            if (digit_count == '0 || !room) state_in = ST_TERM;
         end
         ST_TERM: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      dab_ctrl         = '0;
      emit             = 1'b0;
      rsp_character_in = CHAR_NUL;
      rsp_last_in      = 1'b0;
      mag_in           = mag_ff;
      neg_in           = neg_ff;
      bits_in          = bits_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               dab_ctrl.clear = 1'b1;
               neg_in  = value_bits[VALUE_WIDTH-1];
               mag_in  = value_bits[VALUE_WIDTH-1]
                       ? (~value_bits + VALUE_WIDTH'(1)) : value_bits;
               bits_in = BIT_CNT_W'(VALUE_WIDTH);
            end
         end
         ST_CONVERT: begin
            dab_ctrl.shift  = 1'b1;
            dab_ctrl.bit_in = mag_ff[VALUE_WIDTH-1];
            mag_in  = {mag_ff[VALUE_WIDTH-2:0], 1'b0};
            bits_in = bits_ff - BIT_CNT_W'(1);
         end
         ST_SIGN: begin
            // zero prints as a single digit; negatives get a minus sign
            if (digit_count == '0) begin
               emit = room;
               rsp_character_in = CHAR_ZERO;
            end else begin
               emit = neg_ff && room;
               rsp_character_in = CHAR_MINUS;
            end
         end
         ST_DIGIT: begin
            if (digit_count != '0 && room) begin
               emit = 1'b1;
               dab_ctrl.pop = 1'b1;
               rsp_character_in = CHAR_ZERO + {4'd0, top_digit};
            end
         end
         ST_TERM: begin
            emit        = 1'b1;
            rsp_last_in = 1'b1;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
      rsp_valid_in = emit;
      pos_in = accept ? 5'd0 : (emit ? pos_ff + 5'd1 : pos_ff);
   end

   // Hold control state and the buffer size
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         size_ff      <= BUFFER_SIZE_RESET;
         bits_ff      <= '0;
         pos_ff       <= '0;
         neg_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bits_ff      <= bits_in;
         pos_ff       <= pos_in;
         neg_ff       <= neg_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
         if (csr_write_enable) begin
            size_ff <= csr_write_data;
         end
      end
   end

   // Advance the payload registers
   always_ff @(posedge clock) begin
      mag_ff           <= mag_in;
      rsp_character_ff <= rsp_character_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last      = rsp_last_ff;

   // Text characters are a minus sign or a decimal digit
   assign is_text_char = (rsp_character == CHAR_MINUS)
                      || ((rsp_character >= CHAR_ZERO) && (rsp_character <= CHAR_NINE));

   // Checks on the emitted text and on the sequencer
   `SIDT_ASSERT_IMPLIES(a_nul_on_last, clock, reset, rsp_valid && rsp_last, rsp_character == CHAR_NUL)
   `SIDT_ASSERT_IMPLIES(a_text_char, clock, reset, rsp_valid && !rsp_last, is_text_char)
   `SIDT_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy && (size_ff != '0), busy)
   `SIDT_ASSERT_IMPLIES(a_idle_at_last, clock, reset, rsp_valid && rsp_last, !busy)

endmodule

`default_nettype wire
